FILE: sv/esf_pkg.sv
`default_nettype none

package esf_pkg;

  // flight mode codes
  localparam logic [1:0] CLIMB_LEVEL   = 2'd0;
  localparam logic [1:0] CLIMB_DESCEND = 2'd1;
  localparam logic [1:0] ACCEL_CONST   = 2'd0;
  localparam logic [1:0] ACCEL_DECEL   = 2'd1;
  localparam logic       HOLD_MACH     = 1'b1;
  localparam logic       TROPO_HIGH    = 1'b1;

  // results in Q4.12
  localparam logic [15:0] ESF_ZERO = 16'd0;
  localparam logic [15:0] ESF_ONE  = 16'd4096;
  localparam logic [15:0] ESF_LOW  = 16'd1229;
  localparam logic [15:0] ESF_HIGH = 16'd6963;
  localparam logic [15:0] ESF_MAX  = 16'hFFFF;

  localparam logic signed [15:0] LAPSE_RESET = -16'sd2182;

  // reciprocal of five for a 32 bit operand, shift 34
  localparam logic [31:0] RECIP_FIVE = 32'hCCCC_CCCD;
  localparam logic [30:0] X_BASE     = 31'h1000_0000;
  localparam logic [30:0] INV_X_REM0 = 31'h0800_0000;
  localparam logic [29:0] INV_R_REM0 = 30'h0800_0000;
  localparam logic [51:0] RECIP_REM0 = 52'h100_0000;
  localparam logic signed [52:0] D_ONE     = 53'sd268435456;
  localparam logic signed [52:0] D_SAT_MAX = 53'sd16777216;

  // stage bookkeeping
  localparam int LAT       = 85;
  localparam int SIDE_DLY  = 66;
  localparam int I2_DLY    = 29;
  localparam int X_DLY     = 60;
  localparam int K_DLY     = 3;
  localparam int TAIL_DLY  = 16;

  typedef struct packed {
    logic        compute;
    logic        use_l;
    logic        use_k;
    logic        neg;
    logic [15:0] fixed_val;
    logic        fixed_flag;
  } esf_side_t;

  typedef struct packed {
    logic        compute;
    logic        sat;
    logic [15:0] fixed_val;
    logic        fixed_flag;
  } esf_tail_t;

endpackage

`default_nettype wire

FILE: sv/esf_delay.sv
`default_nettype none

module esf_delay #(
  parameter int W = 8,
  parameter int N = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] line [N];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= d;
      for (int i = 1; i < N; i++) begin
        line[i] <= line[i-1];
      end
    end
  end

  assign q = line[N-1];

endmodule

`default_nettype wire

FILE: sv/esf_udiv.sv
`default_nettype none

// restoring divider, one quotient bit per stage
module esf_udiv #(
  parameter int NB = 16,
  parameter int DW = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NB-1:0] num,
  input  logic [DW-1:0] rem0,
  input  logic [DW-1:0] den,
  output logic [NB-1:0] quot
);

  logic [DW-1:0] rem_a [NB];
  logic [DW-1:0] den_a [NB];
  logic [NB-1:0] num_a [NB];
  logic [NB-1:0] quo_a [NB];

  for (genvar k = 0; k < NB; k++) begin : g_step
    logic [DW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [NB-1:0] n_in;
    logic [NB-1:0] q_in;
    logic [DW:0]   t;
    logic [DW:0]   s;
    logic          take;

    if (k == 0) begin : g_first
      assign r_in = rem0;
      assign d_in = den;
      assign n_in = num;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_a[k-1];
      assign d_in = den_a[k-1];
      assign n_in = num_a[k-1];
      assign q_in = quo_a[k-1];
    end

    assign t    = {r_in, n_in[NB-1]};
    assign s    = t - {1'b0, d_in};
    assign take = (t >= {1'b0, d_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_a[k] <= take ? s[DW-1:0] : t[DW-1:0];
        den_a[k] <= d_in;
        num_a[k] <= {n_in[NB-2:0], 1'b0};
        quo_a[k] <= {q_in[NB-2:0], take};
      end
    end
  end

  assign quot = quo_a[NB-1];

endmodule

`default_nettype wire

FILE: sv/esf_isqrt.sv
`default_nettype none

// digit by digit square root, one root bit per stage
module esf_isqrt #(
  parameter int RW = 30
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] op,
  output logic [RW-1:0]   root
);

  logic [RW:0]     rem_a  [RW];
  logic [RW-1:0]   root_a [RW];
  logic [2*RW-1:0] op_a   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic [RW:0]     r_in;
    logic [RW-1:0]   s_in;
    logic [2*RW-1:0] o_in;
    logic [RW+2:0]   t;
    logic [RW+2:0]   trial;
    logic [RW+2:0]   s;
    logic            take;

    if (k == 0) begin : g_first
      assign r_in = '0;
      assign s_in = '0;
      assign o_in = op;
    end else begin : g_next
      assign r_in = rem_a[k-1];
      assign s_in = root_a[k-1];
      assign o_in = op_a[k-1];
    end

    assign t     = {r_in, o_in[2*RW-1 -: 2]};
    assign trial = {1'b0, s_in, 2'b01};
    assign s     = t - trial;
    assign take  = (t >= trial);

    always_ff @(posedge clk) begin
      if (en) begin
        rem_a[k]  <= take ? s[RW:0] : t[RW:0];
        root_a[k] <= {s_in[RW-2:0], take};
        op_a[k]   <= {o_in[2*RW-3:0], 2'b00};
      end
    end
  end

  assign root = root_a[RW-1];

endmodule

`default_nettype wire

FILE: sv/energy_share_factor.sv
// throughput: one word per cycle; the divider and square root chains are
// one bit per stage, and the whole pipeline holds while a result is not taken
// reset: valid bits clear, the lapse register returns to -2182 (Q2.14)
`default_nettype none

module energy_share_factor
  import esf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  climb_mode,
  input  logic [1:0]  accel_mode,
  input  logic        speed_hold,
  input  logic        high_tropo,
  input  logic [15:0] mach_number,
  input  logic [15:0] air_temp,
  input  logic signed [15:0] temp_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] share_factor,
  output logic        saturated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic signed [15:0] lapse_term
);

  logic signed [15:0] lapse;
  logic [LAT:1]       vld;
  logic               en;

  always_ff @(posedge clk) begin
    if (rst) begin
      lapse <= LAPSE_RESET;
    end else if (cfg_valid) begin
      lapse <= lapse_term;
    end
  end

  assign cfg_ready = 1'b1;

  assign en        = !vld[LAT] || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-1:1], in_valid};
    end
  end

  // stage 1: decode, square, signs
  logic signed [17:0] diff_c;
  esf_side_t          side_c;
  logic [31:0]        m2;
  logic [15:0]        abs_lap;
  logic [16:0]        abs_diff1;
  logic [15:0]        temp1;
  esf_side_t          side1;

  assign diff_c = $signed({2'b00, air_temp}) - $signed({{2{temp_offset[15]}}, temp_offset});

  always_comb begin
    side_c.compute    = 1'b0;
    side_c.use_l      = (high_tropo != TROPO_HIGH);
    side_c.use_k      = (speed_hold != HOLD_MACH);
    side_c.neg        = lapse[15] ^ diff_c[17];
    side_c.fixed_val  = ESF_ZERO;
    side_c.fixed_flag = 1'b0;
    if (climb_mode == CLIMB_LEVEL) begin
      side_c.fixed_val = ESF_ZERO;
    end else if (accel_mode == ACCEL_DECEL) begin
      side_c.fixed_val = (climb_mode == CLIMB_DESCEND) ? ESF_LOW : ESF_HIGH;
    end else if (accel_mode != ACCEL_CONST) begin
      side_c.fixed_val = (climb_mode == CLIMB_DESCEND) ? ESF_HIGH : ESF_LOW;
    end else if (speed_hold == HOLD_MACH && high_tropo == TROPO_HIGH) begin
      side_c.fixed_val = ESF_ONE;
    end else if (high_tropo != TROPO_HIGH && air_temp == 16'd0) begin
      side_c.fixed_val  = ESF_MAX;
      side_c.fixed_flag = 1'b1;
    end else begin
      side_c.compute = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2        <= 32'(mach_number) * 32'(mach_number);
      abs_lap   <= lapse[15] ? 16'(-lapse) : lapse;
      abs_diff1 <= diff_c[17] ? 17'(-diff_c) : diff_c[16:0];
      temp1     <= air_temp;
      side1     <= side_c;
    end
  end

  // stage 2
  logic [47:0] lap_m2;
  logic [63:0] fifth_mul;
  logic [16:0] abs_diff2;
  logic [15:0] temp2;

  always_ff @(posedge clk) begin
    if (en) begin
      lap_m2    <= 48'(abs_lap) * 48'(m2);
      fifth_mul <= 64'(m2) * 64'(RECIP_FIVE);
      abs_diff2 <= abs_diff1;
      temp2     <= temp1;
    end
  end

  // stage 3: x = 1 + m2/5
  logic [63:0] prod3;
  logic [30:0] x3;
  logic [15:0] temp3;

  always_ff @(posedge clk) begin
    if (en) begin
      prod3 <= 64'(lap_m2) * 64'(abs_diff2);
      x3    <= X_BASE + 31'(fifth_mul[63:34]);
      temp3 <= temp2;
    end
  end

  // lapse term division by temperature
  logic [63:0] l_quot;

  esf_udiv #(.NB(64), .DW(16)) u_div_lapse (
    .clk  (clk),
    .en   (en),
    .num  (prod3),
    .rem0 (16'd0),
    .den  (temp3),
    .quot (l_quot)
  );

  // kinetic term: x^-2.5 from 1/x squared times 1/sqrt(x)
  logic [29:0] root33;
  logic [28:0] inv_x;
  logic [57:0] inv_x_sq;
  logic [28:0] i2_33;
  logic [28:0] i2_62;
  logic [28:0] inv_root;
  logic [30:0] x63;
  logic [57:0] y_full;
  logic [28:0] y63;
  logic signed [31:0] k64;
  logic signed [31:0] k67;

  esf_isqrt #(.RW(30)) u_sqrt (
    .clk  (clk),
    .en   (en),
    .op   ({1'b0, x3, 28'd0}),
    .root (root33)
  );

  esf_udiv #(.NB(29), .DW(31)) u_div_inv_x (
    .clk  (clk),
    .en   (en),
    .num  (29'd0),
    .rem0 (INV_X_REM0),
    .den  (x3),
    .quot (inv_x)
  );

  assign inv_x_sq = 58'(inv_x) * 58'(inv_x);

  always_ff @(posedge clk) begin
    if (en) begin
      i2_33 <= inv_x_sq[56:28];
    end
  end

  esf_delay #(.W(29), .N(I2_DLY)) u_dly_i2 (
    .clk (clk), .en (en), .d (i2_33), .q (i2_62)
  );

  esf_udiv #(.NB(29), .DW(30)) u_div_inv_root (
    .clk  (clk),
    .en   (en),
    .num  (29'd0),
    .rem0 (INV_R_REM0),
    .den  (root33),
    .quot (inv_root)
  );

  esf_delay #(.W(31), .N(X_DLY)) u_dly_x (
    .clk (clk), .en (en), .d (x3), .q (x63)
  );

  assign y_full = 58'(i2_62) * 58'(inv_root);

  always_ff @(posedge clk) begin
    if (en) begin
      y63 <= y_full[56:28];
      k64 <= $signed({1'b0, x63}) - $signed({3'b000, y63});
    end
  end

  esf_delay #(.W(32), .N(K_DLY)) u_dly_k (
    .clk (clk), .en (en), .d (k64), .q (k67)
  );

  esf_side_t side67;
  logic [$bits(esf_side_t)-1:0] side67_raw;

  esf_delay #(.W($bits(esf_side_t)), .N(SIDE_DLY)) u_dly_side (
    .clk (clk), .en (en), .d (side1), .q (side67_raw)
  );

  assign side67 = esf_side_t'(side67_raw);

  // stage 68: denominator
  logic signed [52:0] l_val;
  logic signed [52:0] d_c;
  logic [51:0]        den68;
  esf_tail_t          tail68;

  assign l_val = side67.neg ? -$signed({3'b000, l_quot[63:14]})
                            : $signed({3'b000, l_quot[63:14]});
  assign d_c = D_ONE + (side67.use_l ? l_val : 53'sd0)
             + (side67.use_k ? 53'(k67) : 53'sd0);

  always_ff @(posedge clk) begin
    if (en) begin
      den68             <= d_c[51:0];
      tail68.compute    <= side67.compute;
      // covers non-positive denominators and quotients above 16 bits
      tail68.sat        <= (d_c <= D_SAT_MAX);
      tail68.fixed_val  <= side67.fixed_val;
      tail68.fixed_flag <= side67.fixed_flag;
    end
  end

  logic [15:0] recip84;
  esf_tail_t   tail84;
  logic [$bits(esf_tail_t)-1:0] tail84_raw;

  esf_udiv #(.NB(16), .DW(52)) u_div_recip (
    .clk  (clk),
    .en   (en),
    .num  (16'd0),
    .rem0 (RECIP_REM0),
    .den  (den68),
    .quot (recip84)
  );

  esf_delay #(.W($bits(esf_tail_t)), .N(TAIL_DLY)) u_dly_tail (
    .clk (clk), .en (en), .d (tail68), .q (tail84_raw)
  );

  assign tail84 = esf_tail_t'(tail84_raw);

  always_ff @(posedge clk) begin
    if (en) begin
      if (!tail84.compute) begin
        share_factor <= tail84.fixed_val;
        saturated    <= tail84.fixed_flag;
      end else if (tail84.sat) begin
        share_factor <= ESF_MAX;
        saturated    <= 1'b1;
      end else begin
        share_factor <= recip84;
        saturated    <= 1'b0;
      end
    end
  end

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input held off with empty output stage");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (out_valid && saturated) |-> (share_factor == ESF_MAX))
    else $error("saturated word without full-scale value");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> vld[1])
    else $error("accepted word lost at pipeline entry");

endmodule

`default_nettype wire

FILE: dv/esf_checker.sv
`timescale 1ns / 100ps

module esf_checker
  import esf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  climb_mode,
  input  logic [1:0]  accel_mode,
  input  logic        speed_hold,
  input  logic        high_tropo,
  input  logic [15:0] mach_number,
  input  logic [15:0] air_temp,
  input  logic signed [15:0] temp_offset,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] share_factor,
  input  logic        saturated,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic signed [15:0] lapse_term,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [15:0] share;
    logic        sat;
  } esf_word_t;

  esf_word_t exp_words[$];
  logic signed [15:0] lapse_copy;

  function automatic longint unsigned root64(longint unsigned v);
    longint unsigned r;
    longint unsigned bb;
    r = 0;
    bb = 64'd1 << 62;
    while (bb > v) bb = bb >> 2;
    while (bb != 0) begin
      if (v >= r + bb) begin
        v = v - (r + bb);
        r = (r >> 1) + bb;
      end else begin
        r = r >> 1;
      end
      bb = bb >> 2;
    end
    return r;
  endfunction

  function automatic esf_word_t reciprocal_q12(longint d);
    esf_word_t w;
    longint unsigned q;
    if (d <= 0) begin
      w.share = ESF_MAX;
      w.sat = 1'b1;
    end else begin
      q = (64'd1 << 40) / longint'(d);
      if (q > 64'hFFFF) begin
        w.share = ESF_MAX;
        w.sat = 1'b1;
      end else begin
        w.share = q[15:0];
        w.sat = 1'b0;
      end
    end
    return w;
  endfunction

  function automatic esf_word_t esf_predict(logic [1:0] cm, logic [1:0] am, logic sh,
                                            logic tr, logic [15:0] mach, logic [15:0] temp,
                                            logic signed [15:0] off, logic signed [15:0] lap);
    esf_word_t w;
    longint unsigned m2, x, r, i1, i2, is_, y, a, b, mag;
    longint lp, diff, d;
    bit neg;
    w.sat = 1'b0;
    w.share = ESF_ZERO;
    if (cm == CLIMB_LEVEL) return w;
    if (am == ACCEL_DECEL) begin
      w.share = (cm == CLIMB_DESCEND) ? ESF_LOW : ESF_HIGH;
      return w;
    end
    if (am != ACCEL_CONST) begin
      w.share = (cm == CLIMB_DESCEND) ? ESF_HIGH : ESF_LOW;
      return w;
    end
    m2 = longint'(mach) * longint'(mach);
    if (sh == HOLD_MACH && tr == TROPO_HIGH) begin
      w.share = ESF_ONE;
      return w;
    end
    if (tr != TROPO_HIGH && temp == 16'd0) begin
      w.share = ESF_MAX;
      w.sat = 1'b1;
      return w;
    end
    d = 64'sd1 << 28;
    if (tr != TROPO_HIGH) begin
      lp = longint'(lap);
      diff = longint'(temp) - longint'(off);
      neg = (lp < 0) != (diff < 0);
      a = (lp < 0 ? -lp : lp);
      a = a * m2;
      b = (diff < 0 ? -diff : diff);
      mag = ((a * b) / longint'(temp)) >> 14;  // 64 bit wrap of the product is intended
      d = neg ? d - longint'(mag) : d + longint'(mag);
    end
    if (sh != HOLD_MACH) begin
      x = (64'd1 << 28) + m2 / 5;
      r = root64(x << 28);
      i1 = (64'd1 << 56) / x;
      i2 = (i1 * i1) >> 28;
      is_ = (64'd1 << 56) / r;
      y = (i2 * is_) >> 28;
      d = d + longint'(x) - longint'(y);
    end
    return reciprocal_q12(d);
  endfunction

  assign pending = exp_words.size();

  always @(posedge clk) begin
    esf_word_t e;
    if (rst) begin
      lapse_copy <= LAPSE_RESET;
      exp_words.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) lapse_copy <= lapse_term;
      if (out_valid && out_ready) begin
        if (exp_words.size() == 0) begin
          if (errors < 10) $display("unexpected word: share %h sat %b", share_factor, saturated);
          errors <= errors + 1;
        end else begin
          e = exp_words.pop_front();
          if (e.share !== share_factor || e.sat !== saturated) begin
            if (errors < 10)
              $display("mismatch: share exp %h got %h, sat exp %b got %b",
                       e.share, share_factor, e.sat, saturated);
            errors <= errors + 1;
          end
        end
      end
      if (in_valid && in_ready)
        exp_words.push_back(esf_predict(climb_mode, accel_mode, speed_hold, high_tropo,
                                        mach_number, air_temp, temp_offset, lapse_copy));
    end
  end

endmodule

FILE: dv/energy_share_factor_tb.sv
`timescale 1ns / 100ps

module energy_share_factor_tb
  import esf_pkg::*;
;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  climb_mode = '0;
  logic [1:0]  accel_mode = '0;
  logic        speed_hold = 1'b0;
  logic        high_tropo = 1'b0;
  logic [15:0] mach_number = '0;
  logic [15:0] air_temp = '0;
  logic signed [15:0] temp_offset = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] share_factor;
  logic        saturated;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic signed [15:0] lapse_term = '0;
  int          errors;
  int          pending;
  bit          no_idle = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  energy_share_factor dut (.*);
  esf_checker chk (.*);

  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= no_idle || ($urandom_range(99) >= 7);
  end

  task automatic send_word(logic [1:0] cm, logic [1:0] am, logic sh, logic tr,
                           logic [15:0] m, logic [15:0] t, logic [15:0] o);
    while (!no_idle && $urandom_range(99) < 7) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    climb_mode <= cm;
    accel_mode <= am;
    speed_hold <= sh;
    high_tropo <= tr;
    mach_number <= m;
    air_temp <= t;
    temp_offset <= o;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // only while the pipeline is empty
  task automatic write_lapse(logic [15:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LAT + 10) @(posedge clk);
    cfg_valid <= 1'b1;
    lapse_term <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random();
    logic [1:0] cm, am;
    logic [15:0] m, t, o;
    int k;
    k = $urandom_range(99);
    cm = (k < 80) ? 2'($urandom_range(1, 2)) : 2'($urandom_range(3));
    am = (k < 65) ? ACCEL_CONST : 2'($urandom_range(3));
    m = ($urandom_range(9) < 7) ? 16'($urandom_range(16'h4000)) : 16'($urandom);
    k = $urandom_range(99);
    t = (k < 75) ? 16'($urandom_range(25600, 40000)) : (k < 78) ? 16'd0 : 16'($urandom);
    o = ($urandom_range(9) < 7) ? 16'($signed(16'($urandom_range(6400))) - 16'sd3200)
                                : 16'($urandom);
    send_word(cm, am, 1'($urandom), 1'($urandom), m, t, o);
  endtask

  initial begin
    logic [15:0] lapse_set[4];
    lapse_set = '{16'h7FFF, 16'h8000, 16'h0000, 16'($urandom)};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // fixed factors, every climb mode with every non-constant accel mode, including the reserved codes
    for (int cm = 0; cm < 4; cm++)
      for (int am = 1; am < 4; am++)
        send_word(2'(cm), 2'(am), 1'b0, 1'b0, 16'h2000, 16'd36000, 16'sd0);
    send_word(CLIMB_DESCEND, ACCEL_CONST, HOLD_MACH, TROPO_HIGH, 16'hFFFF, 16'd0, 16'sd0);
    send_word(CLIMB_DESCEND, ACCEL_CONST, 1'b0, 1'b0, 16'h3000, 16'd0, 16'sd100);
    send_word(CLIMB_DESCEND, ACCEL_CONST, 1'b0, TROPO_HIGH, 16'hFFFF, 16'd0, 16'h8000);
    send_word(CLIMB_DESCEND, ACCEL_CONST, HOLD_MACH, 1'b0, 16'hFFFF, 16'hFFFF, 16'h7FFF);
    send_word(CLIMB_DESCEND, ACCEL_CONST, HOLD_MACH, 1'b0, 16'hFFFF, 16'd1, 16'h8000);
    send_word(CLIMB_DESCEND, ACCEL_CONST, 1'b0, 1'b0, 16'h0000, 16'hFFFF, 16'h7FFF);
    send_word(CLIMB_DESCEND, ACCEL_CONST, 1'b0, 1'b0, 16'hFFFF, 16'hFFFF, 16'h8000);
    send_word(2'd3, ACCEL_CONST, 1'b0, TROPO_HIGH, 16'h3333, 16'd27904, 16'sd0);
    send_word(2'd2, ACCEL_CONST, HOLD_MACH, 1'b0, 16'h3333, 16'd27904, 16'sd1280);
    for (int i = 0; i < 130; i++) send_random();
    for (int p = 0; p < 4; p++) begin
      write_lapse(lapse_set[p]);
      no_idle = (p == 1);
      for (int i = 0; i < 105; i++) send_random();
    end
    no_idle = 1'b0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LAT + 20) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    #3000000;
    $display("Some tests failed");
    $finish;
  end

endmodule

FILE: files.f
sv/esf_pkg.sv
sv/esf_delay.sv
sv/esf_udiv.sv
sv/esf_isqrt.sv
sv/energy_share_factor.sv
dv/esf_checker.sv
dv/energy_share_factor_tb.sv
